// ===== rtl/dscr_pkg.sv =====
// ----------------------------------------------------------------------------
// Display span clip and rotate package
// Shared widths, operation codes, coordinate type and the result word
// layout used by the span clipper and its top level.
// ----------------------------------------------------------------------------
package dscr_pkg;

  localparam int DefPanelWidth  = 240;
  localparam int DefPanelHeight = 320;

  localparam int InW    = 16;
  localparam int CoordW = 18;
  localparam int ColW   = 8;
  localparam int RowW   = 9;
  localparam int CountW = 9;
  localparam int RotW   = 2;
  localparam int OpW    = 2;

  localparam logic [OpW-1:0] OP_PIXEL = 2'd0;
  localparam logic [OpW-1:0] OP_HSPAN = 2'd1;
  localparam logic [OpW-1:0] OP_VSPAN = 2'd2;

  localparam logic [RotW-1:0] ROT_0   = 2'd0;
  localparam logic [RotW-1:0] ROT_90  = 2'd1;
  localparam logic [RotW-1:0] ROT_180 = 2'd2;
  localparam logic [RotW-1:0] ROT_270 = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic              visible;
    logic [ColW-1:0]   column;
    logic [RowW-1:0]   row;
    logic              vertical;
    logic [CountW-1:0] count;
  } dscr_res_t;

endpackage

// ===== rtl/display_span_clip_rotate_top.sv =====
// ----------------------------------------------------------------------------
// Display span clip and rotate: top level
// Each accepted word is held in the input registers, passes through the
// clipper and is captured in the result register as out_valid rises.
// Throughput: one word per cycle; busy is always low, set by the single
// input register to result register pass through the clipper.
// Reset (synchronous, rst_n low) clears the valid flags and rotation to 0.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module display_span_clip_rotate_top #(
  parameter int PANEL_WIDTH  = dscr_pkg::DefPanelWidth,
  parameter int PANEL_HEIGHT = dscr_pkg::DefPanelHeight
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dscr_pkg::RotW-1:0]           cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic [dscr_pkg::OpW-1:0]            in_operation,
  input  logic signed [dscr_pkg::InW-1:0]     in_start_x,
  input  logic signed [dscr_pkg::InW-1:0]     in_start_y,
  input  logic signed [dscr_pkg::InW-1:0]     in_span_length,
  input  logic [dscr_pkg::InW-1:0]            in_pixel_color,
  output logic                                out_valid,
  output logic                                out_visible,
  output logic [dscr_pkg::ColW-1:0]           out_panel_column,
  output logic [dscr_pkg::RowW-1:0]           out_panel_row,
  output logic                                out_vertical_increment,
  output logic [dscr_pkg::CountW-1:0]         out_pixel_count,
  output logic [dscr_pkg::InW-1:0]            out_color
);

  logic [dscr_pkg::RotW-1:0]       rotation_r;
  logic                            in_valid_r;
  logic [dscr_pkg::OpW-1:0]        op_r;
  logic signed [dscr_pkg::InW-1:0] x_r, y_r, len_r;
  logic [dscr_pkg::InW-1:0]        color_r;
  logic                            out_valid_r;
  dscr_pkg::dscr_res_t             res_nxt, res_r;
  logic [dscr_pkg::InW-1:0]        out_color_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r  <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rotation_r <= cfg_wdata;
      end
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r    <= in_operation;
      x_r     <= in_start_x;
      y_r     <= in_start_y;
      len_r   <= in_span_length;
      color_r <= in_pixel_color;
    end
    if (in_valid_r) begin
      res_r       <= res_nxt;
      out_color_r <= color_r;
    end
  end

  dscr_clip #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_clip (
    .rotation   (rotation_r),
    .operation  (op_r),
    .start_x    (x_r),
    .start_y    (y_r),
    .span_length(len_r),
    .res        (res_nxt)
  );

  assign out_valid              = out_valid_r;
  assign out_visible            = res_r.visible;
  assign out_panel_column       = res_r.column;
  assign out_panel_row          = res_r.row;
  assign out_vertical_increment = res_r.vertical;
  assign out_pixel_count        = res_r.count;
  assign out_color              = out_color_r;

endmodule

// ===== rtl/dscr_map.sv =====
// ----------------------------------------------------------------------------
// Display span clip and rotate: point mapper
// Maps a logical point to a physical panel column and row for one of the
// four rotations.
// ----------------------------------------------------------------------------
module dscr_map #(
  parameter int PANEL_WIDTH  = dscr_pkg::DefPanelWidth,
  parameter int PANEL_HEIGHT = dscr_pkg::DefPanelHeight
) (
  input  logic [dscr_pkg::RotW-1:0] rotation,
  input  dscr_pkg::coord_t          px,
  input  dscr_pkg::coord_t          py,
  output dscr_pkg::coord_t          col,
  output dscr_pkg::coord_t          row
);

  localparam dscr_pkg::coord_t WLast = dscr_pkg::CoordW'(PANEL_WIDTH - 1);
  localparam dscr_pkg::coord_t HLast = dscr_pkg::CoordW'(PANEL_HEIGHT - 1);

  always_comb begin
    case (rotation)
      dscr_pkg::ROT_90: begin
        col = WLast - py;
        row = px;
      end
      dscr_pkg::ROT_180: begin
        col = WLast - px;
        row = HLast - py;
      end
      dscr_pkg::ROT_270: begin
        col = py;
        row = HLast - px;
      end
      default: begin
        col = px;
        row = py;
      end
    endcase
  end

endmodule

// ===== rtl/dscr_clip.sv =====
// ----------------------------------------------------------------------------
// Display span clip and rotate: clipper
// Normalises a signed span, clips it to the rotated logical screen and
// picks the first pixel the panel writes, then maps it to a panel address.
// ----------------------------------------------------------------------------
module dscr_clip #(
  parameter int PANEL_WIDTH  = dscr_pkg::DefPanelWidth,
  parameter int PANEL_HEIGHT = dscr_pkg::DefPanelHeight
) (
  input  logic [dscr_pkg::RotW-1:0] rotation,
  input  logic [dscr_pkg::OpW-1:0]  operation,
  input  logic signed [dscr_pkg::InW-1:0] start_x,
  input  logic signed [dscr_pkg::InW-1:0] start_y,
  input  logic signed [dscr_pkg::InW-1:0] span_length,
  output dscr_pkg::dscr_res_t       res
);

  localparam dscr_pkg::coord_t WC = dscr_pkg::CoordW'(PANEL_WIDTH);
  localparam dscr_pkg::coord_t HC = dscr_pkg::CoordW'(PANEL_HEIGHT);
  localparam dscr_pkg::coord_t One = dscr_pkg::CoordW'(1);
  localparam dscr_pkg::coord_t Zero = '0;

  dscr_pkg::coord_t x, y, len, lw, lh;
  dscr_pkg::coord_t run_start, run_lim, lo_raw, hi_raw, lo, hi;
  dscr_pkg::coord_t px, py, col, row, cnt;
  logic odd, x_in, y_in, run_ok, vis, vert;

  assign x   = {{(dscr_pkg::CoordW - dscr_pkg::InW){start_x[dscr_pkg::InW-1]}}, start_x};
  assign y   = {{(dscr_pkg::CoordW - dscr_pkg::InW){start_y[dscr_pkg::InW-1]}}, start_y};
  assign len = {{(dscr_pkg::CoordW - dscr_pkg::InW){span_length[dscr_pkg::InW-1]}},
                span_length};

  assign odd = rotation[0];
  assign lw  = odd ? HC : WC;
  assign lh  = odd ? WC : HC;

  assign x_in = (x >= Zero) && (x < lw);
  assign y_in = (y >= Zero) && (y < lh);

  assign run_start = (operation == dscr_pkg::OP_VSPAN) ? y : x;
  assign run_lim   = (operation == dscr_pkg::OP_VSPAN) ? lh : lw;

  always_comb begin
    if (len < Zero) begin
      lo_raw = run_start + len + One;
      hi_raw = run_start;
    end else begin
      lo_raw = run_start;
      hi_raw = run_start + len - One;
    end
    lo     = (lo_raw < Zero) ? Zero : lo_raw;
    hi     = (hi_raw > run_lim - One) ? run_lim - One : hi_raw;
    run_ok = (len != Zero) && (lo <= hi);
    cnt    = hi - lo + One;
  end

  always_comb begin
    vis  = 1'b0;
    vert = 1'b0;
    px   = x;
    py   = y;
    case (operation)
      dscr_pkg::OP_PIXEL: begin
        vis = x_in && y_in;
      end
      dscr_pkg::OP_HSPAN: begin
        vis  = y_in && run_ok;
        vert = odd;
        px   = (rotation == dscr_pkg::ROT_180 || rotation == dscr_pkg::ROT_270) ? hi : lo;
      end
      dscr_pkg::OP_VSPAN: begin
        vis  = x_in && run_ok;
        vert = !odd;
        py   = (rotation == dscr_pkg::ROT_90 || rotation == dscr_pkg::ROT_180) ? hi : lo;
      end
      default: begin
        vis = 1'b0;
      end
    endcase
  end

  dscr_map #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_map (
    .rotation(rotation),
    .px      (px),
    .py      (py),
    .col     (col),
    .row     (row)
  );

  always_comb begin
    res.visible  = vis;
    res.column   = vis ? col[dscr_pkg::ColW-1:0] : '0;
    res.row      = vis ? row[dscr_pkg::RowW-1:0] : '0;
    res.vertical = vis ? vert : 1'b0;
    if (!vis) begin
      res.count = '0;
    end else if (operation == dscr_pkg::OP_PIXEL) begin
      res.count = dscr_pkg::CountW'(1);
    end else begin
      res.count = cnt[dscr_pkg::CountW-1:0];
    end
  end

endmodule

// ===== tb/tb_display_span_clip_rotate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span clip and rotate testbench
// Sends pixel and span requests through the start/busy command port and
// checks every result word against a local model of the clipper and rotator.
// Each phase takes its rotation and sender gap rate from a table. The
// rotation is only changed once all outstanding words have been checked.
// ----------------------------------------------------------------------------
module tb_display_span_clip_rotate_top;

  localparam int PanelW = dscr_pkg::DefPanelWidth;
  localparam int PanelH = dscr_pkg::DefPanelHeight;
  localparam logic [dscr_pkg::OpW-1:0] OP_RESERVED = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 68;
  localparam int NumPhases = 6;

  typedef struct {
    logic [dscr_pkg::OpW-1:0]        op;
    logic signed [dscr_pkg::InW-1:0] x;
    logic signed [dscr_pkg::InW-1:0] y;
    logic signed [dscr_pkg::InW-1:0] len;
    logic [dscr_pkg::InW-1:0]        color;
  } span_req_t;

  typedef struct {
    logic                        vis;
    logic [dscr_pkg::ColW-1:0]   col;
    logic [dscr_pkg::RowW-1:0]   row;
    logic                        vert;
    logic [dscr_pkg::CountW-1:0] count;
    logic [dscr_pkg::InW-1:0]    color;
  } span_res_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [dscr_pkg::RotW-1:0]       cfg_wdata = dscr_pkg::ROT_0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [dscr_pkg::OpW-1:0]        in_operation = dscr_pkg::OP_PIXEL;
  logic signed [dscr_pkg::InW-1:0] in_start_x = '0;
  logic signed [dscr_pkg::InW-1:0] in_start_y = '0;
  logic signed [dscr_pkg::InW-1:0] in_span_length = '0;
  logic [dscr_pkg::InW-1:0]        in_pixel_color = '0;
  logic                            out_valid;
  logic                            out_visible;
  logic [dscr_pkg::ColW-1:0]       out_panel_column;
  logic [dscr_pkg::RowW-1:0]       out_panel_row;
  logic                            out_vertical_increment;
  logic [dscr_pkg::CountW-1:0]     out_pixel_count;
  logic [dscr_pkg::InW-1:0]        out_color;

  span_req_t                 pending_reqs[$];
  span_res_t                 expected_words[$];
  span_req_t                 req_on_ports;
  logic [dscr_pkg::RotW-1:0] model_rotation = dscr_pkg::ROT_0;
  int                        idle_pct = 0;
  int                        err_count = 0;
  int                        cycle_count = 0;
  int                        accepted = 0;
  int                        visible_seen = 0;
  int                        op_seen[4] = '{0, 0, 0, 0};
  logic [dscr_pkg::RotW-1:0] phase_rot[NumPhases] = '{dscr_pkg::ROT_90, dscr_pkg::ROT_180,
                                                      dscr_pkg::ROT_270, dscr_pkg::ROT_0,
                                                      dscr_pkg::ROT_90, dscr_pkg::ROT_270};
  int                        phase_idle[NumPhases] = '{48, 38, 0, 48, 38, 0};

  display_span_clip_rotate_top uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_start_x             (in_start_x),
    .in_start_y             (in_start_y),
    .in_span_length         (in_span_length),
    .in_pixel_color         (in_pixel_color),
    .out_valid              (out_valid),
    .out_visible            (out_visible),
    .out_panel_column       (out_panel_column),
    .out_panel_row          (out_panel_row),
    .out_vertical_increment (out_vertical_increment),
    .out_pixel_count        (out_pixel_count),
    .out_color              (out_color)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void to_panel(input logic [dscr_pkg::RotW-1:0] rot, input int lx,
                                   input int ly, output int col, output int row);
    case (rot)
      dscr_pkg::ROT_90: begin
        col = PanelW - 1 - ly;
        row = lx;
      end
      dscr_pkg::ROT_180: begin
        col = PanelW - 1 - lx;
        row = PanelH - 1 - ly;
      end
      dscr_pkg::ROT_270: begin
        col = ly;
        row = PanelH - 1 - lx;
      end
      default: begin
        col = lx;
        row = ly;
      end
    endcase
  endfunction

  function automatic bit clip_span(input int a, input int n, input int lim,
                                   output int lo, output int hi);
    lo = (a < 0) ? 0 : a;
    hi = (a + n - 1 > lim - 1) ? lim - 1 : a + n - 1;
    return (n > 0) && (lo <= hi);
  endfunction

  function automatic span_res_t clip_and_rotate(input span_req_t r,
                                                input logic [dscr_pkg::RotW-1:0] rot);
    span_res_t res;
    bit odd;
    bit vis;
    int lw, lh, x, y, len, n, first, lo, hi, col, row, cnt, vert;
    odd = rot[0];
    lw = odd ? PanelH : PanelW;
    lh = odd ? PanelW : PanelH;
    x = int'(r.x);
    y = int'(r.y);
    len = int'(r.len);
    vis = 1'b0;
    col = 0;
    row = 0;
    cnt = 0;
    vert = 0;
    // A negative length covers the pixels that end at the start point.
    if (len < 0) begin
      n = -len;
      first = len + 1;
    end else begin
      n = len;
      first = 0;
    end
    case (r.op)
      dscr_pkg::OP_PIXEL: begin
        if (x >= 0 && y >= 0 && x < lw && y < lh) begin
          vis = 1'b1;
          to_panel(rot, x, y, col, row);
          cnt = 1;
        end
      end
      dscr_pkg::OP_HSPAN: begin
        if (y >= 0 && y < lh && clip_span(x + first, n, lw, lo, hi)) begin
          vis = 1'b1;
          cnt = hi - lo + 1;
          to_panel(rot, (rot == dscr_pkg::ROT_180 || rot == dscr_pkg::ROT_270) ? hi : lo, y,
                   col, row);
          vert = odd;
        end
      end
      dscr_pkg::OP_VSPAN: begin
        if (x >= 0 && x < lw && clip_span(y + first, n, lh, lo, hi)) begin
          vis = 1'b1;
          cnt = hi - lo + 1;
          to_panel(rot, x, (rot == dscr_pkg::ROT_90 || rot == dscr_pkg::ROT_180) ? hi : lo,
                   col, row);
          vert = !odd;
        end
      end
      default: ;
    endcase
    if (!vis) begin
      col = 0;
      row = 0;
      cnt = 0;
      vert = 0;
    end
    res.vis = vis;
    res.col = col[dscr_pkg::ColW-1:0];
    res.row = row[dscr_pkg::RowW-1:0];
    res.vert = vert[0];
    res.count = cnt[dscr_pkg::CountW-1:0];
    res.color = r.color;
    return res;
  endfunction

  function automatic void queue_req(input logic [dscr_pkg::OpW-1:0] op, input int x,
                                    input int y, input int len,
                                    input logic [dscr_pkg::InW-1:0] color);
    span_req_t r;
    r.op = op;
    r.x = dscr_pkg::InW'(x);
    r.y = dscr_pkg::InW'(y);
    r.len = dscr_pkg::InW'(len);
    r.color = color;
    pending_reqs.push_back(r);
  endfunction

  // Most coordinates land near the screen so that clipping is exercised;
  // the rest cover the full 16-bit range.
  function automatic int rand_coord(input int span);
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 2 * span) - span;
    return int'($signed(16'($urandom())));
  endfunction

  task automatic fill_random(input int n);
    logic [dscr_pkg::OpW-1:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 99) < 5) ? OP_RESERVED : dscr_pkg::OpW'($urandom_range(0, 2));
      queue_req(op, rand_coord(400), rand_coord(400), rand_coord(360), 16'($urandom()));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_words.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_rotation(input logic [dscr_pkg::RotW-1:0] rot);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= rot;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: records accepted words and presents the next pending request.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      model_rotation = dscr_pkg::ROT_0;
    end else begin
      if (cfg_we) model_rotation = cfg_wdata;
      if (start && !busy) begin
        expected_words.push_back(clip_and_rotate(req_on_ports, model_rotation));
        accepted++;
        op_seen[req_on_ports.op]++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        req_on_ports = pending_reqs.pop_front();
        start <= 1'b1;
        in_operation <= req_on_ports.op;
        in_start_x <= req_on_ports.x;
        in_start_y <= req_on_ports.y;
        in_span_length <= req_on_ports.len;
        in_pixel_color <= req_on_ports.color;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each result word is compared with the oldest expectation.
  always @(posedge clk) begin
    span_res_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with no request outstanding", $time);
        err_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_visible) visible_seen++;
        if (out_visible !== exp_w.vis) begin
          $display("%0t: visible expected %0d actual %0d", $time, exp_w.vis, out_visible);
          err_count++;
        end
        if (out_panel_column !== exp_w.col) begin
          $display("%0t: panel_column expected %0d actual %0d", $time, exp_w.col,
                   out_panel_column);
          err_count++;
        end
        if (out_panel_row !== exp_w.row) begin
          $display("%0t: panel_row expected %0d actual %0d", $time, exp_w.row, out_panel_row);
          err_count++;
        end
        if (out_vertical_increment !== exp_w.vert) begin
          $display("%0t: vertical_increment expected %0d actual %0d", $time, exp_w.vert,
                   out_vertical_increment);
          err_count++;
        end
        if (out_pixel_count !== exp_w.count) begin
          $display("%0t: pixel_count expected %0d actual %0d", $time, exp_w.count,
                   out_pixel_count);
          err_count++;
        end
        if (out_color !== exp_w.color) begin
          $display("%0t: color expected %h actual %h", $time, exp_w.color, out_color);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("display_span_clip_rotate_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset rotation.
    idle_pct = 0;
    queue_req(dscr_pkg::OP_PIXEL, 0, 0, 0, 16'h0000);
    queue_req(dscr_pkg::OP_PIXEL, 239, 319, 0, 16'hFFFF);
    queue_req(dscr_pkg::OP_PIXEL, -1, 5, 3, 16'h0001);
    queue_req(dscr_pkg::OP_PIXEL, 240, 5, 0, 16'h8000);
    queue_req(dscr_pkg::OP_PIXEL, 5, 320, -7, 16'h5555);
    queue_req(dscr_pkg::OP_PIXEL, -32768, 32767, 32767, 16'hAAAA);
    queue_req(dscr_pkg::OP_HSPAN, 10, 10, 0, 16'h1111);
    queue_req(dscr_pkg::OP_HSPAN, -32768, 0, 32767, 16'h2222);
    queue_req(dscr_pkg::OP_HSPAN, 32767, 319, -32768, 16'h3333);
    queue_req(dscr_pkg::OP_HSPAN, 0, 7, -1, 16'h4444);
    queue_req(dscr_pkg::OP_HSPAN, 2, 7, -5, 16'h6666);
    queue_req(dscr_pkg::OP_HSPAN, 230, 100, 50, 16'h7777);
    queue_req(dscr_pkg::OP_HSPAN, 5, -1, 10, 16'h8888);
    queue_req(dscr_pkg::OP_HSPAN, 5, 320, 10, 16'h9999);
    queue_req(dscr_pkg::OP_HSPAN, 239, 0, -240, 16'hBBBB);
    queue_req(dscr_pkg::OP_HSPAN, -10, 50, 5, 16'hCCCC);
    queue_req(dscr_pkg::OP_VSPAN, 5, 315, 10, 16'hDDDD);
    queue_req(dscr_pkg::OP_VSPAN, 5, 3, -10, 16'hEEEE);
    queue_req(dscr_pkg::OP_VSPAN, 240, 0, 5, 16'h0F0F);
    queue_req(dscr_pkg::OP_VSPAN, 0, -32768, 32767, 16'hF0F0);
    queue_req(dscr_pkg::OP_VSPAN, 239, 319, -320, 16'h00FF);
    queue_req(dscr_pkg::OP_VSPAN, -1, 0, 5, 16'hFF00);
    queue_req(dscr_pkg::OP_VSPAN, 100, 0, 1, 16'h8001);
    queue_req(OP_RESERVED, 1, 1, 1, 16'h1234);
    fill_random(PhaseItems);
    wait_drained();

    // Every phase ends with the sender held until all words are back.
    for (int i = 0; i < NumPhases; i++) begin
      write_rotation(phase_rot[i]);
      idle_pct = phase_idle[i];
      fill_random(PhaseItems);
      wait_drained();
    end

    $display("Sent %0d requests (%0d pixel, %0d horizontal, %0d vertical, %0d invalid)",
             accepted, op_seen[dscr_pkg::OP_PIXEL], op_seen[dscr_pkg::OP_HSPAN],
             op_seen[dscr_pkg::OP_VSPAN], op_seen[OP_RESERVED]);
    $display("under all four rotations; %0d words visible, %0d clipped away.",
             visible_seen, accepted - visible_seen);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("display_span_clip_rotate_top verification clean");
    end else begin
      $display("display_span_clip_rotate_top verification failed");
    end
    $finish;
  end

endmodule
